// ----- rtl/edf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_pkg: shared types for the EDF tick scheduler
// Sequencer states, request kinds and the per-cell control word.
// ----------------------------------------------------------------------------
package edf_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } edf_state_t;

    // Request kinds carried in s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Control word from the sequencer to each cell
    typedef struct packed {
        logic load;    // write new task entry into this cell
        logic apply;   // tick update of this cell
        logic picked;  // this cell won the selection
        logic in_use;  // slot index below tasks_in_use
    } edf_cell_ctrl_t;

endpackage : edf_pkg
`default_nettype wire

// ----- rtl/edf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_cell: one task slot of the scheduler chain
// Holds the slot's job, period, work and countdown; compares itself with the
// candidate from its left neighbour and registers the winner to the right.
// ----------------------------------------------------------------------------
module edf_cell
    import edf_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int IDX_W     = 3,
    parameter int CELL_IDX  = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire edf_cell_ctrl_t                ctrl,
    input  wire logic [TIME_BITS-1:0]          load_job,
    input  wire logic [TIME_BITS-1:0]          load_period,
    input  wire logic                          cand_found_in,
    input  wire logic signed [TIME_BITS+1:0]   cand_best_in,
    input  wire logic [IDX_W-1:0]              cand_pick_in,
    output logic                               cand_found_out,
    output logic signed [TIME_BITS+1:0]        cand_best_out,
    output logic [IDX_W-1:0]                   cand_pick_out
);

    localparam int CD_W = TIME_BITS + 2;
    localparam logic signed [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [TIME_BITS-1:0]     job_reg, period_reg;
    logic [TIME_BITS-1:0]     work_reg, work_next;
    logic signed [CD_W-1:0]   cd_reg, cd_next;
    logic                     rel_reg, rel_next;

    logic [TIME_BITS-1:0]     wl1;
    logic signed [CD_W-1:0]   d_ext, load_d_ext, cd1, cd2;
    logic                     finish, rel2, take;

    logic                     found_reg;
    logic signed [CD_W-1:0]   best_reg;
    logic [IDX_W-1:0]         pick_reg;

    assign d_ext      = signed'({2'b00, period_reg});
    assign load_d_ext = signed'({2'b00, load_period});

    // Tick update
    always_comb begin
        wl1       = ctrl.picked ? (work_reg - TIME_BITS'(1)) : work_reg;
        cd1       = (cd_reg > CD_MIN) ? (cd_reg - CD_W'(1)) : cd_reg;
        finish    = (wl1 == '0) && rel_reg;
        cd2       = finish ? (cd1 + d_ext) : cd1;
        rel2      = finish ? 1'b0 : rel_reg;
        work_next = wl1;
        cd_next   = cd2;
        rel_next  = rel2;
        if (!rel2 && (cd2 <= d_ext)) begin
            work_next = job_reg;
            rel_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= '0;
            cd_reg   <= '0;
            rel_reg  <= 1'b0;
        end else if (ctrl.load) begin
            work_reg <= load_job;
            cd_reg   <= load_d_ext;
            rel_reg  <= 1'b1;
        end else if (ctrl.apply && ctrl.in_use) begin
            work_reg <= work_next;
            cd_reg   <= cd_next;
            rel_reg  <= rel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            job_reg    <= load_job;
            period_reg <= load_period;
        end
    end

    // Selection: ties go to the higher index, so <= lets this cell win
    assign take = ctrl.in_use && (work_reg != '0) &&
                  (!cand_found_in || (cd_reg <= cand_best_in));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= take | cand_found_in;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= take ? cd_reg : cand_best_in;
        pick_reg <= take ? MY_IDX : cand_pick_in;
    end

    assign cand_found_out = found_reg;
    assign cand_best_out  = best_reg;
    assign cand_pick_out  = pick_reg;

endmodule : edf_cell
`default_nettype wire

// ----- rtl/edf_tick_scheduler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_tick_scheduler_top: earliest-deadline-first periodic task scheduler
// Row of task cells with a registered candidate chain and a tick sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: req_type; tdata: slot, work,
//          |     |                    |   relative deadline
//  m_      | out | m_tvalid/m_tready  | tuser: idle; tdata: running slot
//  cfg_    | in  | cfg_we             | cfg_wdata: tasks_in_use
//
//  Load word: written into its slot on accept, no result word.
//  Tick word: the candidate ripples one cell per cycle through the chain,
//    then the cells take their tick update; one result word.
//  Update cycle waits while a previous result word is still unread.
//  Synchronous active-low reset clears work, countdowns and release flags;
//    job and period entries are undefined until loaded.
// ----------------------------------------------------------------------------
module edf_tick_scheduler_top
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 8,
    parameter int TIME_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // task_slot[2:0], work_amount[18:3],
                                        // relative_deadline[34:19], zero pad
    input  wire logic [0:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // running_slot[2:0], zero pad
    output logic [0:0]       m_tuser,   // idle
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata  // tasks_in_use
);

    localparam int CD_W  = TIME_BITS + 2;
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_TASKS - 1);

    // Configuration
    logic [3:0] tasks_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tasks_in_use_reg <= 4'd1;
        end else if (cfg_we) begin
            tasks_in_use_reg <= cfg_wdata;
        end
    end

    // Input word fields
    logic                 s_accept, load_fire, tick_fire;
    logic [2:0]           in_slot;
    logic [TIME_BITS-1:0] in_job, in_period;

    assign in_slot   = s_tdata[2:0];
    assign in_job    = TIME_BITS'(s_tdata[18:3]);
    assign in_period = TIME_BITS'(s_tdata[34:19]);
    assign s_accept  = s_tvalid && s_tready;
    assign load_fire = s_accept && (s_tuser[0] == REQ_LOAD);
    assign tick_fire = s_accept && (s_tuser[0] == REQ_TICK);

    // Sequencer
    edf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_free, apply_fire;
    logic             m_tvalid_reg;
    logic [2:0]       slot_reg;
    logic             idle_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        apply_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (tick_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // count until the candidate chain has settled after the tick
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SCAN_LAST) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    apply_fire = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Candidate chain: stage 0 is an empty candidate
    logic                 cand_found [0:MAX_TASKS];
    logic signed [CD_W-1:0] cand_best [0:MAX_TASKS];
    logic [IDX_W-1:0]     cand_pick  [0:MAX_TASKS];

    assign cand_found[0] = 1'b0;
    assign cand_best[0]  = '0;
    assign cand_pick[0]  = '0;

    logic             win_found;
    logic [IDX_W-1:0] win_pick;

    assign win_found = cand_found[MAX_TASKS];
    assign win_pick  = cand_pick[MAX_TASKS];

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        edf_cell_ctrl_t ctrl;

        assign ctrl.load   = load_fire && (32'(in_slot) == 32'(i));
        assign ctrl.apply  = apply_fire;
        assign ctrl.picked = apply_fire && win_found && (win_pick == IDX_W'(i));
        assign ctrl.in_use = (32'(tasks_in_use_reg) > 32'(i));

        edf_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (i)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .load_job       (in_job),
            .load_period    (in_period),
            .cand_found_in  (cand_found[i]),
            .cand_best_in   (cand_best[i]),
            .cand_pick_in   (cand_pick[i]),
            .cand_found_out (cand_found[i+1]),
            .cand_best_out  (cand_best[i+1]),
            .cand_pick_out  (cand_pick[i+1])
        );
    end

    // Output register
    logic [IDX_W+2:0] pick_ext;

    assign pick_ext = {3'b000, win_pick};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_fire) begin
            slot_reg <= win_found ? pick_ext[2:0] : 3'd0;
            idle_reg <= !win_found;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {5'b00000, slot_reg};
    assign m_tuser[0] = idle_reg;

    // Checks
    a_tick_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire |=> (state_reg == ST_SCAN))
        else $error("tick word did not start a scan");

    a_apply_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        apply_fire |=> (m_tvalid_reg && (state_reg == ST_IDLE)))
        else $error("update cycle did not leave a result word");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= SCAN_LAST))
        else $error("scan counter ran past the chain length");

    a_idle_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && idle_reg) |-> (slot_reg == 3'd0))
        else $error("idle result carries a non-zero slot");

endmodule : edf_tick_scheduler_top
`default_nettype wire
